// File: rtl/core/upi_pkg.sv
// ----------------------------------------------------------------------------
// upi_pkg
// Shared types, constants and fixed-point helpers of the unicycle pose
// integrator.
// ----------------------------------------------------------------------------
package upi_pkg;

  localparam int unsigned RateW    = 24;
  localparam int unsigned PosW     = 32;
  localparam int unsigned AngleW   = 16;
  localparam int unsigned DtW      = 16;
  localparam int unsigned TrigW    = 18;
  localparam int unsigned TrigMagW = 17;

  localparam logic [DtW-1:0]      StepTimeReset = 16'd6554;
  localparam logic [AngleW-1:0]   QuarterTurn   = 16'h4000;
  localparam logic [TrigMagW-1:0] UnitQ16       = 17'h10000;
  localparam logic [63:0]         HalfPiQ30     = 64'd1686629713;

  typedef logic signed [TrigW-1:0] trig_t;

  typedef struct packed {
    logic [AngleW-1:0]      heading;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_x;
  } pose_t;

  // v * dt / 65536, rounded to nearest, ties away from zero
  function automatic trig_t scale_trig(input trig_t v, input logic [DtW-1:0] dt);
    logic [TrigMagW-1:0]     mag;
    logic [TrigMagW+DtW-1:0] prod;
    logic [TrigMagW-1:0]     q;
    mag  = v[TrigW-1] ? TrigMagW'(-v) : TrigMagW'(v);
    prod = (TrigMagW+DtW)'(mag) * (TrigMagW+DtW)'(dt) + (TrigMagW+DtW)'(32768);
    q    = prod[TrigMagW+DtW-1:DtW];
    return v[TrigW-1] ? -trig_t'({1'b0, q}) : trig_t'({1'b0, q});
  endfunction

  // low bits of turn_rate * dt / 65536, same rounding
  function automatic logic [AngleW-1:0] scale_rate(input logic signed [RateW-1:0] v,
                                                   input logic [DtW-1:0] dt);
    logic [RateW-1:0]     mag;
    logic [RateW+DtW-1:0] prod;
    logic [AngleW-1:0]    q;
    mag  = v[RateW-1] ? RateW'(-v) : RateW'(v);
    prod = (RateW+DtW)'(mag) * (RateW+DtW)'(dt) + (RateW+DtW)'(32768);
    q    = prod[DtW+AngleW-1:DtW];
    return v[RateW-1] ? -q : q;
  endfunction

  function automatic logic signed [PosW-1:0] sat_add(input logic signed [PosW-1:0] base,
                                                     input trig_t d);
    logic [PosW:0] s;
    s = {base[PosW-1], base} + {{(PosW+1-TrigW){d[TrigW-1]}}, d};
    if (s[PosW] != s[PosW-1]) begin
      return s[PosW] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
    end
    return s[PosW-1:0];
  endfunction

endpackage

// File: rtl/core/upi_trig.sv
// ----------------------------------------------------------------------------
// upi_trig
// Quarter-wave sine ROM with registered sine and cosine of the heading.
// ----------------------------------------------------------------------------
module upi_trig #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [upi_pkg::AngleW-1:0]  heading_i,
  output upi_pkg::trig_t              sin_o,
  output upi_pkg::trig_t              cos_o
);

  localparam int unsigned AddrW = $clog2(SINE_TABLE_DEPTH + 1);

  logic [upi_pkg::TrigMagW-1:0] rom_mem [SINE_TABLE_DEPTH+1];

  for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [63:0] T0  = (64'(gi) * upi_pkg::HalfPiQ30) / SINE_TABLE_DEPTH;
    localparam logic [63:0] T2  = (T0 * T0) >> 30;
    localparam logic [63:0] Te1 = ((T0  * T2) >> 30) / 64'd6;
    localparam logic [63:0] Te2 = ((Te1 * T2) >> 30) / 64'd20;
    localparam logic [63:0] Te3 = ((Te2 * T2) >> 30) / 64'd42;
    localparam logic [63:0] Te4 = ((Te3 * T2) >> 30) / 64'd72;
    localparam logic [63:0] Te5 = ((Te4 * T2) >> 30) / 64'd110;
    localparam logic [63:0] Te6 = ((Te5 * T2) >> 30) / 64'd156;
    localparam logic [63:0] Sum = T0 - Te1 + Te2 - Te3 + Te4 - Te5 + Te6;
    localparam logic [63:0] Rnd = (Sum + 64'd8192) >> 14;
    localparam logic [63:0] Ent = (Rnd > 64'd65536) ? 64'd65536 : Rnd;
    assign rom_mem[gi] = upi_pkg::TrigMagW'(Ent);
  end

  logic [upi_pkg::AngleW-1:0] angle [2];
  logic [AddrW-1:0]           addr  [2];
  logic                       neg_d [2];
  logic [AddrW-1:0]           idx;

  logic [upi_pkg::TrigMagW-1:0] mag_q [2];
  logic                         neg_q [2];

  always_comb begin
    idx      = '0;
    angle[0] = heading_i;
    angle[1] = heading_i + upi_pkg::QuarterTurn;
    for (int ln = 0; ln < 2; ln++) begin
      idx       = AddrW'((32'(angle[ln][13:0]) * 32'(SINE_TABLE_DEPTH)) >> 14);
      addr[ln]  = angle[ln][14] ? AddrW'(SINE_TABLE_DEPTH) - idx : idx;
      neg_d[ln] = angle[ln][15];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q[0] <= '0;
      neg_q[0] <= 1'b0;
      mag_q[1] <= upi_pkg::UnitQ16;
      neg_q[1] <= 1'b0;
    end else if (en_i) begin
      mag_q[0] <= rom_mem[addr[0]];
      neg_q[0] <= neg_d[0];
      mag_q[1] <= rom_mem[addr[1]];
      neg_q[1] <= neg_d[1];
    end
  end

  assign sin_o = neg_q[0] ? -upi_pkg::trig_t'({1'b0, mag_q[0]})
                          :  upi_pkg::trig_t'({1'b0, mag_q[0]});
  assign cos_o = neg_q[1] ? -upi_pkg::trig_t'({1'b0, mag_q[1]})
                          :  upi_pkg::trig_t'({1'b0, mag_q[1]});

endmodule

// File: rtl/core/upi_update.sv
// ----------------------------------------------------------------------------
// upi_update
// Forward-Euler pose step: scale trig and turn rate by dt, saturate, wrap.
// ----------------------------------------------------------------------------
module upi_update (
  input  upi_pkg::pose_t                    pose_i,
  input  upi_pkg::trig_t                    sin_i,
  input  upi_pkg::trig_t                    cos_i,
  input  logic signed [upi_pkg::RateW-1:0]  rate_i,
  input  logic [upi_pkg::DtW-1:0]           dt_i,
  output upi_pkg::pose_t                    pose_o
);

  upi_pkg::trig_t             dx;
  upi_pkg::trig_t             dy;
  logic [upi_pkg::AngleW-1:0] dh;

  always_comb begin
    dx             = upi_pkg::scale_trig(cos_i, dt_i);
    dy             = upi_pkg::scale_trig(sin_i, dt_i);
    dh             = upi_pkg::scale_rate(rate_i, dt_i);
    pose_o.pos_x   = upi_pkg::sat_add(pose_i.pos_x, dx);
    pose_o.pos_y   = upi_pkg::sat_add(pose_i.pos_y, dy);
    pose_o.heading = pose_i.heading + dh;
  end

endmodule

// File: rtl/core/unicycle_pose_integrator.sv
// ----------------------------------------------------------------------------
// unicycle_pose_integrator
// Dead-reckoning pose integrator for a unit-speed unicycle, forward Euler.
//
//   channel | dir | tdata / data fields (lsb first)        | tuser
//   s_axis  | in  | turn_rate[23:0]                        | -
//   m_axis  | out | pos_x[31:0] pos_y[63:32] heading[79:64]| -
//   cfg     | in  | step_time[15:0], written on cfg_we_i   | -
//
// One beat in per cycle unless the output stalls; one result per beat.
// The loop runs heading update, sine ROM read and position add.
// Sine and cosine of the held heading sit in registers ahead of use.
// An output stall holds the pose; one more input beat waits in the input stage.
// Reset clears the pose to zero heading at the origin and dt to 6554.
// ----------------------------------------------------------------------------
module unicycle_pose_integrator #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // turn_rate[23:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata    // pos_x[31:0], pos_y[63:32], heading_out[79:64]
);

  logic [upi_pkg::DtW-1:0]          dt_q;
  logic                             in_vld_q;
  logic signed [upi_pkg::RateW-1:0] rate_q;
  logic                             out_vld_q;
  upi_pkg::pose_t                   pose_q;
  upi_pkg::pose_t                   pose_d;
  upi_pkg::trig_t                   sin_val;
  upi_pkg::trig_t                   cos_val;
  logic                             fire;
  logic                             in_take;

  assign fire          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || fire;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  upi_update u_update (
    .pose_i (pose_q),
    .sin_i  (sin_val),
    .cos_i  (cos_val),
    .rate_i (rate_q),
    .dt_i   (dt_q),
    .pose_o (pose_d)
  );

  upi_trig #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_trig (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (fire),
    .heading_i (pose_d.heading),
    .sin_o     (sin_val),
    .cos_o     (cos_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q      <= upi_pkg::StepTimeReset;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pose_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        dt_q <= cfg_wdata_i;
      end
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        pose_q    <= pose_d;
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      rate_q <= s_axis_tdata;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = pose_q;

endmodule

// File: rtl/core/upi_checker.sv
// ----------------------------------------------------------------------------
// upi_checker
// Port-level checks of the pose integrator, bound to the top level.
// ----------------------------------------------------------------------------
module upi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result beat dropped or changed under stall");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_beat_delivered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> ##2 m_axis_tvalid)
    else $error("accepted beat gave no result");

  a_pose_moves_with_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(m_axis_tdata) |-> m_axis_tvalid)
    else $error("pose changed without a result beat");

endmodule

bind unicycle_pose_integrator upi_checker u_upi_checker (.*);
